// ----- sv/plpt_pkg.sv -----
`default_nettype none

package plpt_pkg;

  localparam int unsigned MAX_THREADS_DEF = 16;
  localparam int unsigned LOW_DEPTH_DEF   = 4;
  localparam int unsigned LOW_USED_RST    = 4;

  localparam int unsigned TID_W  = 4;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned SLOT_W = 2;
  localparam int unsigned CFG_W  = 3;
  localparam int unsigned ERR_W  = 2;

  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

  localparam logic [ST_W-1:0] ST_DISABLED = 2'd0;
  localparam logic [ST_W-1:0] ST_ENABLED  = 2'd1;
  localparam logic [ST_W-1:0] ST_SLEEPING = 2'd2;
  localparam logic [ST_W-1:0] ST_RSVD     = 2'd3;

  localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SLOT = 2'd2;

  typedef struct packed {
    logic             v;
    logic [TID_W-1:0] tid;
  } hent_t;

  localparam int unsigned HENT_W = TID_W + 1;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_SH_RD,
    CMD_SH_WR,
    CMD_INS,
    CMD_MH_RD,
    CMD_MH_CHK,
    CMD_ML_CHK,
    CMD_MWR,
    CMD_CINIT,
    CMD_CNT,
    CMD_PH_RD,
    CMD_PH_CHK,
    CMD_PL_CHK,
    CMD_FIN
  } cmd_e;

  typedef struct packed {
    logic go_shift;
    logic go_move;
    logic sh_more;
    logic mh_end;
    logic ml_end;
    logic cnt_last;
    logic ph_end;
    logic pl_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/priority_list_thread_picker.sv -----
// Flow: an accepted beat is loaded and executed; an inserting add then shifts high entries
// to make room and inserts, a move searches high entries, then low slots, and writes its slot;
// then the thread-status scan and the pick scan over high entries and low slots run.
// Throughput: one beat at a time; the next beat is taken the cycle after the result is loaded
// into the output register. The serial thread-status scan and the high-list RAM walks set it.
// Reset (async, active low) disables all threads, empties both lists, low_slots_used = 4.
`default_nettype none

module priority_list_thread_picker import plpt_pkg::*; #(
  parameter int unsigned MAX_THREADS = MAX_THREADS_DEF,
  parameter int unsigned LOW_DEPTH   = LOW_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [OP_W-1:0]   opcode_i,
  input  wire logic [TID_W-1:0]  thread_id_i,
  input  wire logic [ST_W-1:0]   status_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic [SLOT_W-1:0] low_slot_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [TID_W-1:0]       first_thread_o,
  output logic                   first_found_o,
  output logic [TID_W-1:0]       second_thread_o,
  output logic                   second_found_o,
  output logic                   all_sleeping_o,
  output logic [ERR_W-1:0]       error_code_o
);

  cmd_e cmd;
  sts_t sts;

  plpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plpt_dp #(
    .MAX_THREADS (MAX_THREADS),
    .LOW_DEPTH   (LOW_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .thread_id_i     (thread_id_i),
    .status_i        (status_i),
    .position_i      (position_i),
    .low_slot_i      (low_slot_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .first_thread_o  (first_thread_o),
    .first_found_o   (first_found_o),
    .second_thread_o (second_thread_o),
    .second_found_o  (second_found_o),
    .all_sleeping_o  (all_sleeping_o),
    .error_code_o    (error_code_o)
  );

endmodule

`default_nettype wire

// ----- sv/plpt_ram.sv -----
`default_nettype none

module plpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- sv/plpt_ctrl.sv -----
`default_nettype none

module plpt_ctrl import plpt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_e      cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_EXEC   = 15'b000000000000010,
    S_SH_RD  = 15'b000000000000100,
    S_SH_WR  = 15'b000000000001000,
    S_INS    = 15'b000000000010000,
    S_MH_RD  = 15'b000000000100000,
    S_MH_CHK = 15'b000000001000000,
    S_ML_CHK = 15'b000000010000000,
    S_MWR    = 15'b000000100000000,
    S_CINIT  = 15'b000001000000000,
    S_CNT    = 15'b000010000000000,
    S_PH_RD  = 15'b000100000000000,
    S_PH_CHK = 15'b001000000000000,
    S_PL_CHK = 15'b010000000000000,
    S_FIN    = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o = CMD_EXEC;
        priority if (sts_i.go_shift) begin
          state_d = S_SH_RD;
        end else if (sts_i.go_move) begin
          state_d = S_MH_RD;
        end else begin
          state_d = S_CINIT;
        end
      end
      S_SH_RD: begin
        if (sts_i.sh_more) begin
          cmd_o   = CMD_SH_RD;
          state_d = S_SH_WR;
        end else begin
          state_d = S_INS;
        end
      end
      S_SH_WR: begin
        cmd_o   = CMD_SH_WR;
        state_d = S_SH_RD;
      end
      S_INS: begin
        cmd_o   = CMD_INS;
        state_d = S_CINIT;
      end
      S_MH_RD: begin
        if (sts_i.mh_end) begin
          state_d = S_ML_CHK;
        end else begin
          cmd_o   = CMD_MH_RD;
          state_d = S_MH_CHK;
        end
      end
      S_MH_CHK: begin
        cmd_o   = CMD_MH_CHK;
        state_d = S_MH_RD;
      end
      S_ML_CHK: begin
        if (sts_i.ml_end) begin
          state_d = S_MWR;
        end else begin
          cmd_o = CMD_ML_CHK;
        end
      end
      S_MWR: begin
        cmd_o   = CMD_MWR;
        state_d = S_CINIT;
      end
      S_CINIT: begin
        cmd_o   = CMD_CINIT;
        state_d = S_CNT;
      end
      S_CNT: begin
        cmd_o = CMD_CNT;
        if (sts_i.cnt_last) begin
          state_d = S_PH_RD;
        end
      end
      S_PH_RD: begin
        if (sts_i.ph_end) begin
          state_d = S_PL_CHK;
        end else begin
          cmd_o   = CMD_PH_RD;
          state_d = S_PH_CHK;
        end
      end
      S_PH_CHK: begin
        cmd_o   = CMD_PH_CHK;
        state_d = S_PH_RD;
      end
      S_PL_CHK: begin
        if (sts_i.pl_end) begin
          state_d = S_FIN;
        end else begin
          cmd_o = CMD_PL_CHK;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o   = CMD_FIN;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_EXEC))
    else $error("accepted beat did not start execution");

  a_shift_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SH_WR) |-> ($past(state_q) == S_SH_RD))
    else $error("shift write without preceding read");

  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && sts_i.out_free) |=> (state_q == S_IDLE))
    else $error("result load did not return to idle");

endmodule

`default_nettype wire

// ----- sv/plpt_dp.sv -----
`default_nettype none

module plpt_dp import plpt_pkg::*; #(
  parameter int unsigned MAX_THREADS = MAX_THREADS_DEF,
  parameter int unsigned LOW_DEPTH   = LOW_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_e              cmd_i,
  output sts_t                   sts_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic [OP_W-1:0]   opcode_i,
  input  wire logic [TID_W-1:0]  thread_id_i,
  input  wire logic [ST_W-1:0]   status_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic [SLOT_W-1:0] low_slot_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [TID_W-1:0]       first_thread_o,
  output logic                   first_found_o,
  output logic [TID_W-1:0]       second_thread_o,
  output logic                   second_found_o,
  output logic                   all_sleeping_o,
  output logic [ERR_W-1:0]       error_code_o
);

  localparam int unsigned HIW = $clog2(MAX_THREADS);
  localparam int unsigned HCW = $clog2(MAX_THREADS + 1);
  localparam int unsigned LW  = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
  localparam int unsigned LCW = $clog2(LOW_DEPTH + 1);
  localparam int unsigned LOW_RST = (LOW_USED_RST > LOW_DEPTH) ? LOW_DEPTH : LOW_USED_RST;

  logic [OP_W-1:0]   op_q;
  logic [TID_W-1:0]  tid_q;
  logic [ST_W-1:0]   st_q;
  logic [POS_W-1:0]  pos_q;
  logic [SLOT_W-1:0] slot_q;

  logic [MAX_THREADS-1:0] en_q;
  logic [MAX_THREADS-1:0] sl_q;
  logic [HCW-1:0]         hcnt_q;
  logic [LCW-1:0]         nlow_q;
  logic [LOW_DEPTH-1:0]   low_v_q;
  logic [TID_W-1:0]       low_t_q [LOW_DEPTH];

  logic [HCW-1:0]   hidx_q;
  logic [LCW-1:0]   lidx_q;
  logic             found_q;
  logic [1:0]       avail_q;
  logic             slp_q;
  logic [1:0]       hits_q;
  logic [TID_W-1:0] lone_q;
  logic [TID_W-1:0] h1_q;
  logic [TID_W-1:0] h2_q;
  logic [ERR_W-1:0] err_q;
  logic             out_valid_q;

  logic            ram_we;
  logic [HIW-1:0]  ram_waddr;
  hent_t           ram_wdata;
  logic            ram_re;
  logic [HIW-1:0]  ram_raddr;
  hent_t           ram_rdata;

  logic           tid_ok;
  logic [HIW-1:0] tix;
  logic           full;
  logic           slot_ok;
  logic [HCW-1:0] pos_eff;
  logic [LW-1:0]  lix;
  logic [LW-1:0]  six;
  logic           avail_one;
  logic           hit_h;
  logic           low_hit;
  logic           ph_hit;
  logic           pl_hit;
  logic [LCW-1:0] cfg_eff;

  assign tid_ok    = (32'(tid_q) < 32'(MAX_THREADS));
  assign tix       = HIW'(tid_q);
  assign full      = (hcnt_q == HCW'(MAX_THREADS));
  assign slot_ok   = (32'(slot_q) < 32'(nlow_q));
  assign pos_eff   = (32'(pos_q) > 32'(hcnt_q)) ? hcnt_q : HCW'(pos_q);
  assign lix       = LW'(lidx_q);
  assign six       = LW'(slot_q);
  assign avail_one = (avail_q == 2'd1);
  assign hit_h     = ram_rdata.v && (ram_rdata.tid == tid_q);
  assign low_hit   = low_v_q[lix] && (low_t_q[lix] == tid_q);
  assign ph_hit    = ram_rdata.v && en_q[HIW'(ram_rdata.tid)];
  assign pl_hit    = low_v_q[lix] && en_q[HIW'(low_t_q[lix])];

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_eff = LCW'(1);
    end else if (32'(cfg_wdata_i) > 32'(LOW_DEPTH)) begin
      cfg_eff = LCW'(LOW_DEPTH);
    end else begin
      cfg_eff = LCW'(cfg_wdata_i);
    end
  end

  always_comb begin
    sts_o.go_shift = (op_q == OP_ADD) && tid_ok && !full;
    sts_o.go_move  = (op_q == OP_MOVE) && tid_ok && slot_ok;
    sts_o.sh_more  = (hidx_q > pos_eff);
    sts_o.mh_end   = found_q || (hidx_q >= hcnt_q);
    sts_o.ml_end   = found_q || (lidx_q >= nlow_q);
    sts_o.cnt_last = (hidx_q == HCW'(MAX_THREADS - 1));
    sts_o.ph_end   = avail_one || (hits_q == 2'd2) || (hidx_q >= hcnt_q);
    sts_o.pl_end   = avail_one || (hits_q == 2'd2) || (lidx_q >= nlow_q);
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = HIW'(hidx_q);
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = HIW'(hidx_q);
    unique case (cmd_i)
      CMD_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = HIW'(hidx_q - HCW'(1));
      end
      CMD_SH_WR: begin
        ram_we = 1'b1;
      end
      CMD_INS: begin
        ram_we        = 1'b1;
        ram_waddr     = HIW'(pos_eff);
        ram_wdata.v   = 1'b1;
        ram_wdata.tid = tid_q;
      end
      CMD_MH_RD, CMD_PH_RD: begin
        ram_re = 1'b1;
      end
      CMD_MH_CHK: begin
        ram_we    = hit_h;
        ram_wdata = '0;
      end
      default: ;
    endcase
  end

  plpt_ram #(
    .WIDTH (HENT_W),
    .DEPTH (MAX_THREADS)
  ) u_high (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= '0;
      sl_q        <= '0;
      hcnt_q      <= '0;
      nlow_q      <= LCW'(LOW_RST);
      low_v_q     <= '0;
      hidx_q      <= '0;
      lidx_q      <= '0;
      found_q     <= 1'b0;
      avail_q     <= '0;
      slp_q       <= 1'b0;
      hits_q      <= '0;
      err_q       <= ERR_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        nlow_q <= cfg_eff;
        for (int i = 0; i < LOW_DEPTH; i++) begin
          if (i >= int'(cfg_eff)) begin
            low_v_q[i] <= 1'b0;
          end
        end
      end
      if (cmd_i == CMD_FIN) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i)
        CMD_EXEC: begin
          if (tid_ok && op_q == OP_SET && st_q != ST_RSVD) begin
            en_q[tix] <= (st_q == ST_ENABLED);
            sl_q[tix] <= (st_q == ST_SLEEPING);
          end else if (tid_ok && op_q == OP_ADD) begin
            en_q[tix] <= 1'b1;
            sl_q[tix] <= 1'b0;
          end
          if (tid_ok && op_q == OP_ADD && full) begin
            err_q <= ERR_FULL;
          end else if (tid_ok && op_q == OP_MOVE && !slot_ok) begin
            err_q <= ERR_SLOT;
          end else begin
            err_q <= ERR_OK;
          end
          hidx_q  <= (op_q == OP_ADD) ? hcnt_q : '0;
          lidx_q  <= '0;
          found_q <= 1'b0;
        end
        CMD_SH_WR: begin
          hidx_q <= hidx_q - HCW'(1);
        end
        CMD_INS: begin
          hcnt_q <= hcnt_q + HCW'(1);
        end
        CMD_MH_CHK: begin
          if (hit_h) begin
            found_q <= 1'b1;
          end
          hidx_q <= hidx_q + HCW'(1);
        end
        CMD_ML_CHK: begin
          if (low_hit) begin
            low_v_q[lix] <= 1'b0;
            found_q      <= 1'b1;
          end
          lidx_q <= lidx_q + LCW'(1);
        end
        CMD_MWR: begin
          low_v_q[six] <= 1'b1;
        end
        CMD_CINIT: begin
          hidx_q  <= '0;
          lidx_q  <= '0;
          avail_q <= '0;
          slp_q   <= 1'b0;
          hits_q  <= '0;
        end
        CMD_CNT: begin
          if (en_q[HIW'(hidx_q)]) begin
            if (avail_q != 2'd2) begin
              avail_q <= avail_q + 2'd1;
            end
          end else if (sl_q[HIW'(hidx_q)]) begin
            slp_q <= 1'b1;
          end
          hidx_q <= sts_o.cnt_last ? '0 : hidx_q + HCW'(1);
        end
        CMD_PH_CHK: begin
          if (ph_hit) begin
            hits_q <= hits_q + 2'd1;
          end
          hidx_q <= hidx_q + HCW'(1);
        end
        CMD_PL_CHK: begin
          if (pl_hit) begin
            hits_q <= hits_q + 2'd1;
          end
          lidx_q <= lidx_q + LCW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        op_q   <= opcode_i;
        tid_q  <= thread_id_i;
        st_q   <= status_i;
        pos_q  <= position_i;
        slot_q <= low_slot_i;
      end
      CMD_MWR: begin
        low_t_q[six] <= tid_q;
      end
      CMD_CNT: begin
        if (en_q[HIW'(hidx_q)] && avail_q == 2'd0) begin
          lone_q <= TID_W'(hidx_q);
        end
      end
      CMD_PH_CHK: begin
        if (ph_hit) begin
          if (hits_q == 2'd0) begin
            h1_q <= ram_rdata.tid;
          end else begin
            h2_q <= ram_rdata.tid;
          end
        end
      end
      CMD_PL_CHK: begin
        if (pl_hit) begin
          if (hits_q == 2'd0) begin
            h1_q <= low_t_q[lix];
          end else begin
            h2_q <= low_t_q[lix];
          end
        end
      end
      CMD_FIN: begin
        if (avail_one) begin
          first_thread_o  <= lone_q;
          first_found_o   <= 1'b1;
          second_thread_o <= lone_q;
          second_found_o  <= 1'b1;
        end else begin
          first_thread_o  <= (hits_q != 2'd0) ? h1_q : '0;
          first_found_o   <= (hits_q != 2'd0);
          second_thread_o <= (hits_q == 2'd2) ? h2_q : '0;
          second_found_o  <= (hits_q == 2'd2);
        end
        all_sleeping_o <= (avail_q == 2'd0) && slp_q;
        error_code_o   <= err_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_INS) |-> (hcnt_q < HCW'(MAX_THREADS)))
    else $error("insert into full high list");

  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_FIN) |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a waiting beat");

  a_pick_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_PH_CHK || cmd_i == CMD_PL_CHK) |-> (hits_q < 2'd2 && !avail_one))
    else $error("pick scan ran past its end");

endmodule

`default_nettype wire
